// ===== sv/plr_pkg.sv =====
// Package for the positional record list: field widths, operation and status
// codes, transaction structs, and the controller/datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps

package plr_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam int FUNC_W    = 3;
   localparam int POS_W     = 5;
   localparam int ROLL_W    = 16;
   localparam int BYTE_W    = 8;
   localparam int STATUS_W  = 3;
   localparam int IDX_W     = 4;
   localparam int TOTAL_W   = 10;
   localparam int CNT_OUT_W = 5;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_UPDATE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DUMP   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [POS_W-1:0]  position;
      logic [ROLL_W-1:0] roll_no;
      logic [BYTE_W-1:0] gender;
      logic [BYTE_W-1:0] mark_one;
      logic [BYTE_W-1:0] mark_two;
      logic [BYTE_W-1:0] mark_three;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [IDX_W-1:0]     entry_index;
      logic [ROLL_W-1:0]    out_roll_no;
      logic [BYTE_W-1:0]    out_gender;
      logic [TOTAL_W-1:0]   total_marks;
      logic [CNT_OUT_W-1:0] entry_count;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic [BYTE_W-1:0] mark_three;
      logic [BYTE_W-1:0] mark_two;
      logic [BYTE_W-1:0] mark_one;
      logic [BYTE_W-1:0] gender;
      logic [ROLL_W-1:0] roll_no;
   } record_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_POS,
      PTR_LAST,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   typedef enum logic [1:0] {
      EMIT_ERROR,
      EMIT_NEW,
      EMIT_HELD,
      EMIT_READ
   } emit_sel_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_ERROR,
      S_INS_SHIFT,
      S_INS_DRAIN,
      S_INS_PUT,
      S_DEL_OLD,
      S_DEL_KEEP,
      S_DEL_SHIFT,
      S_DEL_DRAIN,
      S_DEL_DONE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_UPD_RD,
      S_UPD_DONE,
      S_DUMP_RD,
      S_DUMP_EMIT
   } state_type;

   typedef struct packed {
      logic                load_req;
      ptr_op_type          ptr_op;
      logic                rd_en;
      logic                mv_up;
      logic                mv_dn;
      logic                keep_old;
      logic                wr_rec;
      logic                cnt_inc;
      logic                cnt_dec;
      logic                emit;
      emit_sel_type        emit_sel;
      logic [STATUS_W-1:0] status;
      logic                last;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              empty;
      logic              full;
      logic              pos_above;
      logic              pos_at_count;
      logic              ptr_at_pos;
      logic              ptr_at_last;
      logic              ptr_at_end;
      logic              key_hit;
      logic              slot_free;
   } sts_type;

endpackage

// ===== sv/plr_ctrl.sv =====
// Controller for the positional record list: operation sequencer that drives the
// datapath through plr_pkg::cmd_type and follows its plr_pkg::sts_type.
// Depends on plr_pkg.
`timescale 1ns / 1ps

module plr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  plr_pkg::sts_type sts,
   output plr_pkg::cmd_type cmd
);
   import plr_pkg::*;

   state_type           state_ff, state_in;
   logic [STATUS_W-1:0] err_ff, err_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         err_ff   <= ST_OK;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      err_in   = err_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            priority if (sts.func == FUNC_INSERT) begin
               priority if (sts.full) begin
                  err_in   = ST_FULL;
                  state_in = S_ERROR;
               end else if (sts.pos_above) begin
                  err_in   = ST_BADPOS;
                  state_in = S_ERROR;
               end else if (sts.pos_at_count) begin
                  state_in = S_INS_PUT;
               end else begin
                  state_in = S_INS_SHIFT;
               end
            end else if (sts.func == FUNC_DELETE || sts.func == FUNC_UPDATE) begin
               priority if (sts.empty) begin
                  err_in   = ST_EMPTY;
                  state_in = S_ERROR;
               end else if (sts.pos_above || sts.pos_at_count) begin
                  err_in   = ST_BADPOS;
                  state_in = S_ERROR;
               end else if (sts.func == FUNC_DELETE) begin
                  state_in = S_DEL_OLD;
               end else begin
                  state_in = S_UPD_RD;
               end
            end else if (sts.func == FUNC_SEARCH || sts.func == FUNC_DUMP) begin
               priority if (sts.empty) begin
                  err_in   = ST_EMPTY;
                  state_in = S_ERROR;
               end else if (sts.func == FUNC_SEARCH) begin
                  state_in = S_SRCH_RD;
               end else begin
                  state_in = S_DUMP_RD;
               end
            end else begin
               // unknown operation: drop without a result
               state_in = S_IDLE;
            end
         end
         S_ERROR:     if (sts.slot_free) state_in = S_IDLE;
         S_INS_SHIFT: if (sts.ptr_at_pos) state_in = S_INS_DRAIN;
         S_INS_DRAIN: state_in = S_INS_PUT;
         S_INS_PUT:   if (sts.slot_free) state_in = S_IDLE;
         S_DEL_OLD:   state_in = S_DEL_KEEP;
         S_DEL_KEEP: begin
            priority if (sts.ptr_at_end) state_in = S_DEL_DONE;
            else if (sts.ptr_at_last) state_in = S_DEL_DRAIN;
            else state_in = S_DEL_SHIFT;
         end
         S_DEL_SHIFT: if (sts.ptr_at_last) state_in = S_DEL_DRAIN;
         S_DEL_DRAIN: state_in = S_DEL_DONE;
         S_DEL_DONE:  if (sts.slot_free) state_in = S_IDLE;
         S_SRCH_RD:   state_in = S_SRCH_CMP;
         S_SRCH_CMP: begin
            priority if (sts.key_hit) begin
               if (sts.slot_free) state_in = S_IDLE;
            end else if (sts.ptr_at_end) begin
               err_in   = ST_NOTFOUND;
               state_in = S_ERROR;
            end else begin
               state_in = S_SRCH_CMP;
            end
         end
         S_UPD_RD:    state_in = S_UPD_DONE;
         S_UPD_DONE:  if (sts.slot_free) state_in = S_IDLE;
         S_DUMP_RD:   state_in = S_DUMP_EMIT;
         S_DUMP_EMIT: if (sts.slot_free && sts.ptr_at_end) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.ptr_op   = PTR_HOLD;
      cmd.emit_sel = EMIT_ERROR;
      cmd.status   = ST_OK;
      cmd.last     = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         S_CHECK: begin
            priority if (sts.func == FUNC_INSERT) cmd.ptr_op = PTR_LAST;
            else if (sts.func == FUNC_DELETE || sts.func == FUNC_UPDATE) cmd.ptr_op = PTR_POS;
            else cmd.ptr_op = PTR_ZERO;
         end
         S_ERROR: begin
            cmd.emit     = sts.slot_free;
            cmd.emit_sel = EMIT_ERROR;
            cmd.status   = err_ff;
         end
         S_INS_SHIFT: begin
            cmd.rd_en = 1'b1;
            cmd.mv_up = 1'b1;
            if (!sts.ptr_at_pos) cmd.ptr_op = PTR_DEC;
         end
         S_INS_DRAIN: begin
            cmd.ptr_op = PTR_HOLD;
         end
         S_INS_PUT: begin
            if (sts.slot_free) begin
               cmd.wr_rec   = 1'b1;
               cmd.cnt_inc  = 1'b1;
               cmd.emit     = 1'b1;
               cmd.emit_sel = EMIT_NEW;
            end
         end
         S_DEL_OLD: begin
            cmd.rd_en  = 1'b1;
            cmd.ptr_op = PTR_INC;
         end
         S_DEL_KEEP: begin
            cmd.keep_old = 1'b1;
            if (!sts.ptr_at_end) begin
               cmd.rd_en  = 1'b1;
               cmd.mv_dn  = 1'b1;
               cmd.ptr_op = PTR_INC;
            end
         end
         S_DEL_SHIFT: begin
            cmd.rd_en  = 1'b1;
            cmd.mv_dn  = 1'b1;
            cmd.ptr_op = PTR_INC;
         end
         S_DEL_DRAIN: begin
            cmd.ptr_op = PTR_HOLD;
         end
         S_DEL_DONE: begin
            if (sts.slot_free) begin
               cmd.cnt_dec  = 1'b1;
               cmd.emit     = 1'b1;
               cmd.emit_sel = EMIT_HELD;
            end
         end
         S_SRCH_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.ptr_op = PTR_INC;
         end
         S_SRCH_CMP: begin
            priority if (sts.key_hit) begin
               cmd.emit     = sts.slot_free;
               cmd.emit_sel = EMIT_READ;
            end else if (sts.ptr_at_end) begin
               cmd.ptr_op = PTR_HOLD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.ptr_op = PTR_INC;
            end
         end
         S_UPD_RD: begin
            cmd.rd_en = 1'b1;
         end
         S_UPD_DONE: begin
            if (sts.slot_free) begin
               cmd.wr_rec   = 1'b1;
               cmd.emit     = 1'b1;
               cmd.emit_sel = EMIT_READ;
            end
         end
         S_DUMP_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.ptr_op = PTR_INC;
         end
         S_DUMP_EMIT: begin
            if (sts.slot_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = EMIT_READ;
               cmd.last     = sts.ptr_at_end;
               if (!sts.ptr_at_end) begin
                  cmd.rd_en  = 1'b1;
                  cmd.ptr_op = PTR_INC;
               end
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== sv/plr_dpath.sv =====
// Datapath for the positional record list: record memory, entry count, walk
// pointer, move pipeline and the registered response stage.
// Depends on plr_pkg; driven by plr_ctrl.
`timescale 1ns / 1ps

module plr_dpath #(
   parameter int CAPACITY = plr_pkg::CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  plr_pkg::req_type req_data,
   input  plr_pkg::cmd_type cmd,
   output plr_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output plr_pkg::rsp_type rsp_data
);
   import plr_pkg::*;

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   req_type    req_ff;
   record_type records_ff [CAPACITY];
   record_type rd_data_ff;
   logic [AW-1:0] rd_idx_ff;
   record_type hold_ff;
   logic [AW-1:0] wa_ff, wa_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff, rsp_in;

   record_type      new_rec;
   logic [CMPW-1:0] pos_ext;
   logic [CMPW-1:0] cnt_ext;
   logic [CMPW-1:0] rd_idx_ext;
   logic [CMPW-1:0] cnt_next_ext;
   logic [AW-1:0]   pos_addr;
   logic            slot_free;

   function automatic logic [TOTAL_W-1:0] mark_total(record_type r);
      return TOTAL_W'(r.mark_one) + TOTAL_W'(r.mark_two) + TOTAL_W'(r.mark_three);
   endfunction

   assign new_rec.roll_no    = req_ff.roll_no;
   assign new_rec.gender     = req_ff.gender;
   assign new_rec.mark_one   = req_ff.mark_one;
   assign new_rec.mark_two   = req_ff.mark_two;
   assign new_rec.mark_three = req_ff.mark_three;

   assign pos_ext      = CMPW'(req_ff.position);
   assign cnt_ext      = CMPW'(count_ff);
   assign rd_idx_ext   = CMPW'(rd_idx_ff);
   assign cnt_next_ext = CMPW'(count_in);
   assign pos_addr     = pos_ext[AW-1:0];
   assign slot_free    = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_data;
   end

   // record memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_rec) begin
         records_ff[pos_addr] <= new_rec;
      end else if (pend_ff) begin
         records_ff[wa_ff] <= rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= records_ff[ptr_ff[AW-1:0]];
         rd_idx_ff  <= ptr_ff[AW-1:0];
      end
      if (cmd.keep_old) hold_ff <= rd_data_ff;
   end

   // a move reads its source now and writes the neighbor in the following cycle
   always_comb begin
      pend_in = cmd.mv_up || cmd.mv_dn;
      wa_in   = wa_ff;
      if (cmd.mv_up) wa_in = ptr_ff[AW-1:0] + AW'(1);
      else if (cmd.mv_dn) wa_in = ptr_ff[AW-1:0] - AW'(1);
   end

   always_ff @(posedge clock) begin
      wa_ff <= wa_in;
      if (reset) pend_ff <= 1'b0;
      else pend_ff <= pend_in;
   end

   always_comb begin
      unique case (cmd.ptr_op)
         PTR_HOLD: ptr_in = ptr_ff;
         PTR_ZERO: ptr_in = '0;
         PTR_POS:  ptr_in = pos_ext[CW-1:0];
         PTR_LAST: ptr_in = count_ff - CW'(1);
         PTR_INC:  ptr_in = ptr_ff + CW'(1);
         PTR_DEC:  ptr_in = ptr_ff - CW'(1);
         default:  ptr_in = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) count_in = count_ff + CW'(1);
      else if (cmd.cnt_dec) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end

   // response assembly
   always_comb begin
      rsp_in             = '0;
      rsp_in.status      = cmd.status;
      rsp_in.entry_count = cnt_next_ext[CNT_OUT_W-1:0];
      rsp_in.last        = cmd.last;
      unique case (cmd.emit_sel)
         EMIT_ERROR: begin
            rsp_in.last = 1'b1;
         end
         EMIT_NEW: begin
            rsp_in.entry_index = pos_ext[IDX_W-1:0];
            rsp_in.out_roll_no = new_rec.roll_no;
            rsp_in.out_gender  = new_rec.gender;
            rsp_in.total_marks = mark_total(new_rec);
         end
         EMIT_HELD: begin
            rsp_in.entry_index = pos_ext[IDX_W-1:0];
            rsp_in.out_roll_no = hold_ff.roll_no;
            rsp_in.out_gender  = hold_ff.gender;
            rsp_in.total_marks = mark_total(hold_ff);
         end
         EMIT_READ: begin
            rsp_in.entry_index = rd_idx_ext[IDX_W-1:0];
            rsp_in.out_roll_no = rd_data_ff.roll_no;
            rsp_in.out_gender  = rd_data_ff.gender;
            rsp_in.total_marks = mark_total(rd_data_ff);
         end
         default: begin
            rsp_in.last = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign sts.func         = req_ff.func;
   assign sts.empty        = (count_ff == '0);
   assign sts.full         = (count_ff == CW'(CAPACITY));
   assign sts.pos_above    = (pos_ext > cnt_ext);
   assign sts.pos_at_count = (pos_ext == cnt_ext);
   assign sts.ptr_at_pos   = (CMPW'(ptr_ff) == pos_ext);
   assign sts.ptr_at_last  = ((ptr_ff + CW'(1)) == count_ff);
   assign sts.ptr_at_end   = (ptr_ff == count_ff);
   assign sts.key_hit      = (rd_data_ff.roll_no == req_ff.roll_no);
   assign sts.slot_free    = slot_free;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> slot_free)
      else $error("response issued into an occupied output register");

   a_write_port: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_rec && pend_ff))
      else $error("record write collides with a pending move");

   a_count_on_emit: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> $past(cmd.emit))
      else $error("entry count changed without a response");

endmodule

// ===== sv/positional_record_list_top.sv =====
// Positional record list. Insert below the end and delete walk the entries from the position to
// the last; search walks from index 0 to the hit or the end; dump gives one response per entry,
// one per cycle while the output register is free (rsp_ready holds it otherwise).
// One transaction at a time; the next is accepted in the cycle after the final response issues,
// and the walk through the single-read-port record memory sets the rate.
// Synchronous active-high reset clears the count and the control state; memory is not cleared.
`timescale 1ns / 1ps

module positional_record_list_top #(
   parameter int CAPACITY = plr_pkg::CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  plr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output plr_pkg::rsp_type rsp_data
);
   import plr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   plr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   plr_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
